FILE: sv/b64e_pkg.sv
// Shared types, constants and the character function of the Base64 stream encoder.
// No dependencies; the front end, queue, back end and top level import it.
package b64e_pkg;

	localparam int QueueDepth = 2;

	localparam logic [6:0] PadChar = 7'h3D;

	// One input group: up to three bytes, how many of them are real, and
	// whether it closes the message. Missing bytes are zero.
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] n;
		logic       last;
	} group_t;

	// Maps a six-bit value to its character in the standard alphabet.
	function automatic logic [6:0] sym(input logic [5:0] v);
		logic [6:0] w;
		logic [6:0] c;
		begin
			w = {1'b0, v};
			if (v < 6'd26) begin
				c = w + 7'h41;
			end else if (v < 6'd52) begin
				c = w - 7'd26 + 7'h61;
			end else if (v < 6'd62) begin
				c = w - 7'd52 + 7'h30;
			end else if (v == 6'd62) begin
				c = 7'h2B;
			end else begin
				c = 7'h2F;
			end
			return c;
		end
	endfunction

endpackage

FILE: sv/b64e_front.sv
// Front end of the Base64 encoder: takes bytes, holds up to two of them and
// emits a complete or final group toward the queue. Depends on b64e_pkg.
module b64e_front import b64e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	input  logic       q_full,
	output logic       q_push,
	output group_t     q_data
);

	logic [15:0] pend_q;
	logic [1:0]  cnt_q;
	logic        accept;
	logic        full_cnt;

	assign byte_stall = q_full;
	assign accept     = byte_valid && !q_full;
	// A count of three cannot occur; it is handled like two.
	assign full_cnt   = cnt_q[1];
	assign q_push     = accept && (full_cnt || end_of_message);

	always_comb begin
		q_data.last = end_of_message;
		q_data.b2   = 8'h00;
		if (full_cnt) begin
			q_data.b0 = pend_q[15:8];
			q_data.b1 = pend_q[7:0];
			q_data.b2 = data_byte;
			q_data.n  = 2'd3;
		end else if (cnt_q == 2'd1) begin
			q_data.b0 = pend_q[15:8];
			q_data.b1 = data_byte;
			q_data.n  = 2'd2;
		end else begin
			q_data.b0 = data_byte;
			q_data.b1 = 8'h00;
			q_data.n  = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			pend_q <= 16'h0000;
		end else if (accept) begin
			if (q_push) begin
				cnt_q  <= 2'd0;
				pend_q <= 16'h0000;
			end else if (cnt_q == 2'd0) begin
				cnt_q  <= 2'd1;
				pend_q <= {data_byte, 8'h00};
			end else begin
				cnt_q  <= 2'd2;
				pend_q <= {pend_q[15:8], data_byte};
			end
		end
	end

endmodule

FILE: sv/b64e_queue.sv
// Short group queue between the front and back ends of the Base64 encoder.
// Depends on b64e_pkg for the group type.
module b64e_queue import b64e_pkg::*; #(
	parameter int Depth = QueueDepth
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  group_t push_data,
	output logic   full,
	input  logic   pop,
	output logic   not_empty,
	output group_t pop_data
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	group_t            mem [Depth];
	logic [PtrW-1:0]   wr_q;
	logic [PtrW-1:0]   rd_q;
	logic [CntW-1:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (cnt_q == CntW'(Depth));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/b64e_back.sv
// Back end of the Base64 encoder (needs b64e_pkg): turns each queued group
// into four characters, one per cycle unless stalled, via an output register.
module b64e_back import b64e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_not_empty,
	input  group_t     q_data,
	output logic       q_pop,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [6:0] out_char,
	output logic       last_char
);

	group_t      grp_q;
	logic        active_q;
	logic [1:0]  idx_q;
	logic        valid_q;
	logic [6:0]  char_q;
	logic        last_q;
	logic        advance;
	logic        load;
	logic [5:0]  six;
	logic        pad;

	assign advance = active_q && (!valid_q || !char_stall);
	// A new group may enter while the last character of the current one leaves.
	assign load    = q_not_empty && (!active_q || (advance && idx_q == 2'd3));
	assign q_pop   = load;

	always_comb begin
		case (idx_q)
			2'd0:    six = grp_q.b0[7:2];
			2'd1:    six = {grp_q.b0[1:0], grp_q.b1[7:4]};
			2'd2:    six = {grp_q.b1[3:0], grp_q.b2[7:6]};
			default: six = grp_q.b2[5:0];
		endcase
		pad = ((idx_q == 2'd2) && (grp_q.n < 2'd2)) ||
		      ((idx_q == 2'd3) && (grp_q.n < 2'd3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= 2'd0;
			valid_q  <= 1'b0;
		end else begin
			if (load) begin
				active_q <= 1'b1;
				idx_q    <= 2'd0;
			end else if (advance) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					active_q <= 1'b0;
				end
			end
			if (advance) begin
				valid_q <= 1'b1;
			end else if (valid_q && !char_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_q <= q_data;
		end
		if (advance) begin
			char_q <= pad ? PadChar : sym(six);
			last_q <= grp_q.last && (idx_q == 2'd3);
		end
	end

	assign char_valid = valid_q;
	assign out_char   = char_q;
	assign last_char  = last_q;

endmodule

FILE: sv/base64_stream_encoder_top.sv
// Streaming Base64 encoder (standard alphabet, '=' padding).
// Bytes enter on the byte channel with an end-of-message flag; ASCII
// characters leave on the char channel, the final one marked by last_char.
// Every third byte, or a flagged byte, closes a group of four characters;
// a short final group is padded with one or two '=' characters.
// The first character of a group passes through the queue, the group
// register and the character register after the byte that closes the
// group is taken. The single-character output register gives one character
// per cycle while the receiver does not stall; bytes that only fill a
// group are taken one per cycle while the queue is not full.
// A queue of QDepth groups (QueueDepth by default) separates byte intake
// from character output; byte_stall rises only when that queue is full.
// When the receiver stalls, the character register holds its value and the
// back end waits; the front end keeps taking bytes until the queue fills.
// Reset clears the held bytes, the queue and the output valid at once.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
module base64_stream_encoder_top import b64e_pkg::*; #(
	parameter int QDepth = QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [6:0] out_char,
	output logic       last_char
);

	logic   q_full;
	logic   q_push;
	logic   q_pop;
	logic   q_not_empty;
	group_t push_data;
	group_t pop_data;

	b64e_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_data         (push_data)
	);

	b64e_queue #(
		.Depth (QDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (pop_data)
	);

	b64e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (pop_data),
		.q_pop       (q_pop),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.out_char    (out_char),
		.last_char   (last_char)
	);

endmodule

FILE: sv/b64e_checker.sv
// Port-level checker for the Base64 encoder, bound to the top level.
// Tracks the character position within each group of four; depends on b64e_pkg.
module b64e_checker import b64e_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       byte_valid,
	input logic       byte_stall,
	input logic [7:0] data_byte,
	input logic       end_of_message,
	input logic       char_valid,
	input logic       char_stall,
	input logic [6:0] out_char,
	input logic       last_char
);

	logic [1:0] pos_q;
	logic       char_take;

	assign char_take = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
		end else if (char_take) begin
			pos_q <= pos_q + 2'd1;
		end
	end

	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=>
			byte_valid && $stable(data_byte) && $stable(end_of_message))
		else $error("stalled byte changed");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=> char_valid && $stable(out_char) && $stable(last_char))
		else $error("stalled character changed");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		char_take && last_char |-> pos_q == 2'd3)
		else $error("last character not at end of a group");

	a_pad_pos: assert property (@(posedge clk) disable iff (!arst_n)
		char_take && out_char == PadChar |-> pos_q == 2'd2 || pos_q == 2'd3)
		else $error("pad character in the first half of a group");

	a_pad_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_take && out_char == PadChar && pos_q == 2'd3 |-> last_char)
		else $error("padded group does not end the message");

endmodule

bind base64_stream_encoder_top b64e_checker u_chk (.*);
